[rtl/core/sst_pkg.sv]
// Package with shared types, constants and the keyword and operator tables of the tokenizer.
`timescale 1ns / 1ps
package sst_pkg;

	localparam int unsigned PositionBitsDefault = 16;
	localparam int unsigned NumKeywords = 25;
	localparam int unsigned MaxRecords = 5;
	localparam int unsigned RecCountBits = 3;

	localparam logic [5:0] KindIdent = 6'd25;
	localparam logic [5:0] KindNumber = 6'd26;
	localparam logic [5:0] KindUnknown = 6'd27;
	localparam logic [5:0] KindString = 6'd28;
	localparam logic [5:0] KindEof = 6'd29;
	localparam logic [5:0] KindNone = 6'd63;

	localparam logic [1:0] ErrNone = 2'd0;
	localparam logic [1:0] ErrUnexpected = 2'd1;
	localparam logic [1:0] ErrUnterminated = 2'd2;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChStar = 8'h2A;
	localparam logic [7:0] ChUnderscore = 8'h5F;
	localparam logic [7:0] ChDot = 8'h2E;
	localparam logic [7:0] ChNewline = 8'h0A;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'd0,
		MODE_HELD  = 4'd1,
		MODE_WORD  = 4'd2,
		MODE_NUM   = 4'd3,
		MODE_STR   = 4'd4,
		MODE_ESC   = 4'd5,
		MODE_LCOMM = 4'd6,
		MODE_BCOMM = 4'd7,
		MODE_DEAD  = 4'd8
	} scan_mode_t;

	typedef struct packed {
		logic       record_type;
		logic [7:0] lexeme_byte;
		logic [5:0] token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [1:0] error_code;
	} rec_t;

	typedef rec_t [MaxRecords-1:0] rec_list_t;

	// Keyword text, nine bytes each, first byte in the lowest bits.
	function automatic logic [71:0] kw_text(input logic [4:0] k);
		case (k)
			5'd0: kw_text = {48'h0, "rav"};
			5'd1: kw_text = {32'h0, "tsnoc"};
			5'd2: kw_text = {48'h0, "nuf"};
			5'd3: kw_text = {24'h0, "nruter"};
			5'd4: kw_text = {56'h0, "fi"};
			5'd5: kw_text = {40'h0, "esle"};
			5'd6: kw_text = {32'h0, "elihw"};
			5'd7: kw_text = {48'h0, "rof"};
			5'd8: kw_text = {32'h0, "kaerb"};
			5'd9: kw_text = {8'h0, "eunitnoc"};
			5'd10: kw_text = {56'h0, "ni"};
			5'd11: kw_text = {32'h0, "tnirp"};
			5'd12: kw_text = {32'h0, "nwaps"};
			5'd13: kw_text = {16'h0, "yortsed"};
			5'd14: kw_text = {56'h0, "no"};
			5'd15: kw_text = {32'h0, "tneve"};
			5'd16: kw_text = {40'h0, "time"};
			5'd17: kw_text = {8'h0, "tcartnoc"};
			5'd18: kw_text = {24'h0, "yfirev"};
			5'd19: kw_text = {24'h0, "ytitne"};
			5'd20: kw_text = "tnenopmoc";
			5'd21: kw_text = {40'h0, "fles"};
			5'd22: kw_text = {40'h0, "eurt"};
			5'd23: kw_text = {32'h0, "eslaf"};
			5'd24: kw_text = {40'h0, "llun"};
			default: kw_text = '0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input logic [4:0] k);
		case (k)
			5'd0, 5'd2, 5'd7: kw_len = 4'd3;
			5'd4, 5'd10, 5'd14: kw_len = 4'd2;
			5'd5, 5'd16, 5'd21, 5'd22, 5'd24: kw_len = 4'd4;
			5'd3, 5'd18, 5'd19: kw_len = 4'd6;
			5'd13: kw_len = 4'd7;
			5'd9, 5'd17: kw_len = 4'd8;
			5'd20: kw_len = 4'd9;
			default: kw_len = 4'd5;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_held_op(input logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "=", "!", "<", ">", "&", "|": is_held_op = 1'b1;
			default: is_held_op = 1'b0;
		endcase
	endfunction

	// Two-character operator kind, KindNone when the pair does not combine.
	function automatic logic [5:0] op_pair(input logic [7:0] h, input logic [7:0] c);
		op_pair = KindNone;
		if (c == "=") begin
			case (h)
				"+": op_pair = 6'd30;
				"-": op_pair = 6'd32;
				"*": op_pair = 6'd35;
				"/": op_pair = 6'd37;
				"=": op_pair = 6'd40;
				"!": op_pair = 6'd42;
				"<": op_pair = 6'd44;
				">": op_pair = 6'd46;
				default: op_pair = KindNone;
			endcase
		end else if (h == "-" && c == ">") begin
			op_pair = 6'd33;
		end else if (h == "&" && c == "&") begin
			op_pair = 6'd48;
		end else if (h == "|" && c == "|") begin
			op_pair = 6'd50;
		end
	endfunction

	function automatic logic [5:0] op_single(input logic [7:0] h);
		case (h)
			"+": op_single = 6'd31;
			"-": op_single = 6'd34;
			"*": op_single = 6'd36;
			"/": op_single = 6'd38;
			"=": op_single = 6'd41;
			"!": op_single = 6'd43;
			"<": op_single = 6'd45;
			">": op_single = 6'd47;
			"&": op_single = 6'd49;
			default: op_single = 6'd51;
		endcase
	endfunction

	function automatic logic [5:0] op_alone(input logic [7:0] c);
		case (c)
			"%": op_alone = 6'd39;
			"(": op_alone = 6'd52;
			")": op_alone = 6'd53;
			"{": op_alone = 6'd54;
			"}": op_alone = 6'd55;
			"[": op_alone = 6'd56;
			"]": op_alone = 6'd57;
			",": op_alone = 6'd58;
			".": op_alone = 6'd59;
			";": op_alone = 6'd60;
			":": op_alone = 6'd61;
			"?": op_alone = 6'd62;
			default: op_alone = KindNone;
		endcase
	endfunction

endpackage

[rtl/core/sst_scan.sv]
// Scanner: holds the tokenizer state and turns one beat into a list of up to five records.
`timescale 1ns / 1ps
module sst_scan import sst_pkg::*; #(
	parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              src_byte,
	input  logic                    has_byte,
	input  logic                    end_of_source,
	output rec_list_t               recs,
	output logic [RecCountBits-1:0] rec_count
);

	localparam logic [POSITION_BITS-1:0] PosMax = '1;
	localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

	scan_mode_t                 mode_q, mode_d;
	logic [7:0]                 held_q, held_d;
	logic [NumKeywords-1:0]     cand_q, cand_d;
	logic [3:0]                 wlen_q, wlen_d;
	logic                       star_q, star_d;
	logic [POSITION_BITS-1:0]   line_q, line_d, col_q, col_d, tline_q, tline_d;
	logic [POSITION_BITS-1:0]   tcol_q, tcol_d;

	rec_list_t              r;
	logic [RecCountBits-1:0] n;
	logic                   restart, move, eof;
	logic [5:0]             k, wkind;
	logic [7:0]             b;
	logic [7:0]             kw;

	function automatic rec_t mk_byte(input logic [7:0] v);
		rec_t t;
		t = '0;
		t.lexeme_byte = v;
		return t;
	endfunction

	// The output keeps the low 16 bits of a position.
	function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] v);
		return 16'(v);
	endfunction

	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		cand_d = cand_q;
		wlen_d = wlen_q;
		star_d = star_q;
		line_d = line_q;
		col_d = col_q;
		tline_d = tline_q;
		tcol_d = tcol_q;
		r = '0;
		n = '0;
		restart = 1'b0;
		move = 1'b0;
		eof = 1'b1;
		k = KindNone;
		wkind = KindIdent;
		b = src_byte;
		kw = '0;

		if (has_byte) begin
			case (mode_q)
				MODE_IDLE: restart = 1'b1;
				MODE_HELD: begin
					k = op_pair(held_q, b);
					if (k != KindNone) begin
						r[0] = mk_byte(held_q);
						r[1] = mk_byte(b);
						r[2] = '0;
						r[2].record_type = 1'b1;
						r[2].token_kind = k;
						r[2].start_line = pos16(tline_q);
						r[2].start_column = pos16(tcol_q);
						n = 3'd3;
						mode_d = MODE_IDLE;
						move = 1'b1;
					end else if (held_q == ChSlash && (b == ChSlash || b == ChStar)) begin
						mode_d = (b == ChSlash) ? MODE_LCOMM : MODE_BCOMM;
						star_d = 1'b0;
						move = 1'b1;
					end else begin
						r[0] = mk_byte(held_q);
						r[1].record_type = 1'b1;
						r[1].token_kind = op_single(held_q);
						r[1].start_line = pos16(tline_q);
						r[1].start_column = pos16(tcol_q);
						n = 3'd2;
						mode_d = MODE_IDLE;
						restart = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_alpha(b) || is_digit(b) || b == ChUnderscore) begin
						for (int i = 0; i < NumKeywords; i++) begin
							kw = 8'(kw_text(5'(i)) >> {wlen_q, 3'b000});
							if (kw_len(5'(i)) <= wlen_q || kw != b)
								cand_d[i] = 1'b0;
						end
						if (wlen_q != 4'd15) wlen_d = wlen_q + 4'd1;
						r[0] = mk_byte(b);
						n = 3'd1;
						move = 1'b1;
					end else begin
						for (int i = NumKeywords - 1; i >= 0; i--)
							if (cand_q[i] && kw_len(5'(i)) == wlen_q) wkind = 6'(i);
						r[0].record_type = 1'b1;
						r[0].token_kind = wkind;
						r[0].start_line = pos16(tline_q);
						r[0].start_column = pos16(tcol_q);
						n = 3'd1;
						cand_d = '1;
						wlen_d = '0;
						mode_d = MODE_IDLE;
						restart = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(b) || b == ChDot) begin
						r[0] = mk_byte(b);
						n = 3'd1;
						move = 1'b1;
					end else begin
						r[0].record_type = 1'b1;
						r[0].token_kind = KindNumber;
						r[0].start_line = pos16(tline_q);
						r[0].start_column = pos16(tcol_q);
						n = 3'd1;
						mode_d = MODE_IDLE;
						restart = 1'b1;
					end
				end
				MODE_STR: begin
					move = 1'b1;
					if (b == ChQuote) begin
						r[0].record_type = 1'b1;
						r[0].token_kind = KindString;
						r[0].start_line = pos16(tline_q);
						r[0].start_column = pos16(tcol_q);
						n = 3'd1;
						mode_d = MODE_IDLE;
					end else if (b == ChBackslash) begin
						mode_d = MODE_ESC;
					end else begin
						r[0] = mk_byte(b);
						n = 3'd1;
					end
				end
				MODE_ESC: begin
					move = 1'b1;
					mode_d = MODE_STR;
					n = 3'd1;
					case (b)
						"n": r[0] = mk_byte(8'h0A);
						"t": r[0] = mk_byte(8'h09);
						"r": r[0] = mk_byte(8'h0D);
						ChQuote: r[0] = mk_byte(ChQuote);
						ChBackslash: r[0] = mk_byte(ChBackslash);
						default: begin
							r[0] = mk_byte(ChBackslash);
							r[1] = mk_byte(b);
							n = 3'd2;
						end
					endcase
				end
				MODE_LCOMM: begin
					move = 1'b1;
					if (b == ChNewline) mode_d = MODE_IDLE;
				end
				MODE_BCOMM: begin
					move = 1'b1;
					if (star_q && b == ChSlash) begin
						mode_d = MODE_IDLE;
						star_d = 1'b0;
					end else begin
						star_d = (b == ChStar);
					end
				end
				default: ;
			endcase

			if (restart) begin
				move = 1'b1;
				tline_d = line_q;
				tcol_d = col_q;
				k = op_alone(b);
				if (b == " " || b == 8'h09 || b == 8'h0D || b == ChNewline) begin
				end else if (is_digit(b)) begin
					mode_d = MODE_NUM;
					r[n] = mk_byte(b);
					n = n + 3'd1;
				end else if (b == ChQuote) begin
					mode_d = MODE_STR;
				end else if (is_alpha(b) || b == ChUnderscore) begin
					mode_d = MODE_WORD;
					for (int i = 0; i < NumKeywords; i++) begin
						kw = 8'(kw_text(5'(i)));
						cand_d[i] = (kw == b);
					end
					wlen_d = 4'd1;
					r[n] = mk_byte(b);
					n = n + 3'd1;
				end else if (is_held_op(b)) begin
					mode_d = MODE_HELD;
					held_d = b;
				end else begin
					r[n] = mk_byte(b);
					r[n+3'd1].record_type = 1'b1;
					r[n+3'd1].token_kind = (k != KindNone) ? k : KindUnknown;
					r[n+3'd1].start_line = pos16(line_q);
					r[n+3'd1].start_column = pos16(col_q);
					r[n+3'd1].error_code = (k != KindNone) ? ErrNone : ErrUnexpected;
					n = n + 3'd2;
					if (k == KindNone) mode_d = MODE_DEAD;
				end
			end

			if (move) begin
				if (b == ChNewline) begin
					if (line_q != PosMax) line_d = line_q + PosOne;
					col_d = PosOne;
				end else if (col_q != PosMax) begin
					col_d = col_q + PosOne;
				end
			end
		end

		if (end_of_source) begin
			wkind = KindIdent;
			for (int i = NumKeywords - 1; i >= 0; i--)
				if (cand_d[i] && kw_len(5'(i)) == wlen_d) wkind = 6'(i);
			case (mode_d)
				MODE_HELD: begin
					r[n] = mk_byte(held_d);
					r[n+3'd1].record_type = 1'b1;
					r[n+3'd1].token_kind = op_single(held_d);
					r[n+3'd1].start_line = pos16(tline_d);
					r[n+3'd1].start_column = pos16(tcol_d);
					n = n + 3'd2;
				end
				MODE_WORD, MODE_NUM: begin
					r[n].record_type = 1'b1;
					r[n].token_kind = (mode_d == MODE_WORD) ? wkind : KindNumber;
					r[n].start_line = pos16(tline_d);
					r[n].start_column = pos16(tcol_d);
					n = n + 3'd1;
				end
				MODE_ESC, MODE_STR: begin
					if (mode_d == MODE_ESC) begin
						r[n] = mk_byte(ChBackslash);
						n = n + 3'd1;
					end
					r[n].record_type = 1'b1;
					r[n].token_kind = KindUnknown;
					r[n].start_line = pos16(tline_d);
					r[n].start_column = pos16(tcol_d);
					r[n].error_code = ErrUnterminated;
					n = n + 3'd1;
					eof = 1'b0;
				end
				MODE_DEAD: eof = 1'b0;
				default: ;
			endcase
			if (eof) begin
				r[n].record_type = 1'b1;
				r[n].token_kind = KindEof;
				r[n].start_line = pos16(line_d);
				r[n].start_column = pos16(col_d);
				n = n + 3'd1;
			end
			mode_d = MODE_IDLE;
			held_d = '0;
			cand_d = '1;
			wlen_d = '0;
			star_d = 1'b0;
			line_d = PosOne;
			col_d = PosOne;
			tline_d = PosOne;
			tcol_d = PosOne;
		end
		recs = r;
		rec_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= '0;
			cand_q <= '1;
			wlen_q <= '0;
			star_q <= 1'b0;
			line_q <= PosOne;
			col_q <= PosOne;
			tline_q <= PosOne;
			tcol_q <= PosOne;
		end else if (step) begin
			mode_q <= mode_d;
			held_q <= held_d;
			cand_q <= cand_d;
			wlen_q <= wlen_d;
			star_q <= star_d;
			line_q <= line_d;
			col_q <= col_d;
			tline_q <= tline_d;
			tcol_q <= tcol_d;
		end
	end

endmodule

[rtl/core/sst_emit.sv]
// Result register: holds a record list and sends it out one beat at a time.
`timescale 1ns / 1ps
module sst_emit import sst_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  rec_list_t               recs,
	input  logic [RecCountBits-1:0] rec_count,
	output logic                    busy,
	output logic                    last_beat,
	output rec_t                    cur,
	output logic                    m_valid,
	input  logic                    m_ready
);

	rec_list_t               recs_q;
	logic [RecCountBits-1:0] count_q, idx_q;

	assign busy = (count_q != '0);
	assign m_valid = busy;
	assign cur = recs_q[idx_q];
	assign last_beat = busy && (idx_q + 3'd1 == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			count_q <= rec_count;
			idx_q <= '0;
		end else if (m_valid && m_ready) begin
			if (last_beat) count_q <= '0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) recs_q <= recs;
	end

endmodule

[rtl/core/script_source_tokenizer_core.sv]
// Top level of the streaming source tokenizer.
`timescale 1ns / 1ps
// One source byte per input beat; each beat is scanned combinationally into up to five
// records, which leave one per output beat from a result register, as the output
// handshake allows. The next input beat is taken in the cycle the last record of the
// previous one leaves, so a new byte is not taken while records of the last one still
// wait in the single result port.
module script_source_tokenizer_core import sst_pkg::*; #(
	parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // src_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,   // end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // lexeme_byte, token_kind, start_line, start_column,
	                               // error_code
	output logic        m_tuser,   // record_type
	output logic        m_tlast    // last_of_run
);

	rec_list_t               recs;
	logic [RecCountBits-1:0] rec_count;
	logic                    busy, last_beat, step, load;
	rec_t                    cur;

	assign s_tready = !busy || (last_beat && m_tready);
	assign step = s_tvalid && s_tready;
	assign load = step && (rec_count != '0);

	sst_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .step(step), .src_byte(s_tdata), .has_byte(s_tuser),
		.end_of_source(s_tlast), .recs(recs), .rec_count(rec_count)
	);

	sst_emit u_emit (
		.clk(clk), .arst_n(arst_n), .load(load), .recs(recs), .rec_count(rec_count),
		.busy(busy), .last_beat(last_beat), .cur(cur), .m_valid(m_tvalid),
		.m_ready(m_tready)
	);

	assign m_tdata = {cur.error_code, cur.start_column, cur.start_line,
		cur.token_kind, cur.lexeme_byte};
	assign m_tuser = cur.record_type;
	assign m_tlast = last_beat;

	// A close record always carries a nonzero start line.
	a_close_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[29:14] != 16'd0)
		else $error("close record with zero line");

	// Lexeme records carry no kind.
	a_lex_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[13:8] == 6'd0)
		else $error("lexeme record with kind");

	// Input is never taken while a stalled output run still has records left.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted over stalled output");

endmodule

[tb/tb_script_source_tokenizer_core.sv]
// Self-checking testbench of the streaming source tokenizer with a built-in token predictor.
`timescale 1ns / 1ps
module tb_script_source_tokenizer_core;
	import sst_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       has;
		logic       eos;
	} src_item_t;

	typedef struct {
		logic        rtype;
		logic [7:0]  lex;
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [1:0]  err;
		logic        last;
	} token_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	src_item_t  pending_bytes[$];
	src_item_t  source_buf[$];
	token_rec_t expected_tokens[$];
	token_rec_t step_recs[$];
	int         errors = 0;
	int         tx_idle = 0;
	int         rx_stall = 0;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         hold_cnt = 0;
	int         items_made = 0;

	string kw_words[25] = '{"var", "const", "fun", "return", "if", "else", "while", "for",
		"break", "continue", "in", "print", "spawn", "destroy", "on", "event", "emit",
		"contract", "verify", "entity", "component", "self", "true", "false", "null"};

	scan_mode_t  mode;
	logic [7:0]  held;
	logic [24:0] cand;
	logic [3:0]  wlen;
	logic        star;
	logic [15:0] ln, col, tl, tc;

	script_source_tokenizer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void lexer_reset();
		mode = MODE_IDLE;
		held = '0;
		cand = '1;
		wlen = '0;
		star = 1'b0;
		ln = 16'd1;
		col = 16'd1;
		tl = 16'd1;
		tc = 16'd1;
	endfunction

	function automatic void emit_rec(logic t, logic [7:0] b, logic [5:0] k, logic [15:0] l,
			logic [15:0] c, logic [1:0] e);
		token_rec_t r;
		r.rtype = t;
		r.lex = b;
		r.kind = k;
		r.line = l;
		r.col = c;
		r.err = e;
		r.last = 1'b0;
		if (step_recs.size() < MaxRecords)
			step_recs = {step_recs, r};
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		emit_rec(1'b0, b, '0, '0, '0, ErrNone);
	endfunction

	function automatic void emit_close(logic [5:0] k, logic [1:0] e);
		emit_rec(1'b1, '0, k, tl, tc, e);
	endfunction

	function automatic void advance_pos(logic [7:0] b);
		if (b == ChNewline) begin
			if (ln != 16'hFFFF)
				ln = ln + 1'b1;
			col = 16'd1;
		end else if (col != 16'hFFFF) begin
			col = col + 1'b1;
		end
	endfunction

	function automatic logic digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alpha_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic word_char(logic [7:0] c);
		return alpha_char(c) || digit_char(c) || c == ChUnderscore;
	endfunction

	function automatic void word_push(logic [7:0] b);
		for (int k = 0; k < 25; k++)
			if (cand[k] && (kw_words[k].len() <= wlen || kw_words[k][wlen] != b))
				cand[k] = 1'b0;
		if (wlen != 4'd15)
			wlen = wlen + 1'b1;
	endfunction

	function automatic logic [5:0] word_token_kind();
		for (int k = 0; k < 25; k++)
			if (cand[k] && kw_words[k].len() == wlen)
				return 6'(k);
		return KindIdent;
	endfunction

	// Operator kind tables: pairs, the held byte on its own, and bytes that stand alone.
	function automatic logic [5:0] pair_kind(logic [7:0] h, logic [7:0] c);
		case ({h, c})
			"+=": return 6'd30;
			"-=": return 6'd32;
			"*=": return 6'd35;
			"/=": return 6'd37;
			"==": return 6'd40;
			"!=": return 6'd42;
			"<=": return 6'd44;
			">=": return 6'd46;
			"->": return 6'd33;
			"&&": return 6'd48;
			"||": return 6'd50;
			default: return KindNone;
		endcase
	endfunction

	function automatic logic [5:0] single_kind(logic [7:0] h);
		case (h)
			"+": return 6'd31;
			"-": return 6'd34;
			"*": return 6'd36;
			"/": return 6'd38;
			"=": return 6'd41;
			"!": return 6'd43;
			"<": return 6'd45;
			">": return 6'd47;
			"&": return 6'd49;
			default: return 6'd51;
		endcase
	endfunction

	function automatic logic [5:0] alone_kind(logic [7:0] c);
		case (c)
			"%": return 6'd39;
			"(": return 6'd52;
			")": return 6'd53;
			"{": return 6'd54;
			"}": return 6'd55;
			"[": return 6'd56;
			"]": return 6'd57;
			",": return 6'd58;
			".": return 6'd59;
			";": return 6'd60;
			":": return 6'd61;
			"?": return 6'd62;
			default: return KindNone;
		endcase
	endfunction

	function automatic logic holds_char(logic [7:0] c);
		return c inside {"+", "-", "*", "/", "=", "!", "<", ">", "&", "|"};
	endfunction

	function automatic void open_token(logic [7:0] b);
		tl = ln;
		tc = col;
		if (b inside {" ", "\t", 8'h0D, ChNewline}) begin
		end else if (digit_char(b)) begin
			mode = MODE_NUM;
			emit_byte(b);
		end else if (b == ChQuote) begin
			mode = MODE_STR;
		end else if (alpha_char(b) || b == ChUnderscore) begin
			mode = MODE_WORD;
			cand = '1;
			wlen = '0;
			word_push(b);
			emit_byte(b);
		end else if (holds_char(b)) begin
			mode = MODE_HELD;
			held = b;
		end else if (alone_kind(b) != KindNone) begin
			emit_byte(b);
			emit_close(alone_kind(b), ErrNone);
		end else begin
			emit_byte(b);
			emit_close(KindUnknown, ErrUnexpected);
			mode = MODE_DEAD;
		end
		advance_pos(b);
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		logic [5:0] k;
		case (mode)
			MODE_IDLE: open_token(b);
			MODE_HELD: begin
				k = pair_kind(held, b);
				if (k != KindNone) begin
					emit_byte(held);
					emit_byte(b);
					emit_close(k, ErrNone);
					mode = MODE_IDLE;
					advance_pos(b);
				end else if (held == ChSlash && (b == ChSlash || b == ChStar)) begin
					mode = (b == ChSlash) ? MODE_LCOMM : MODE_BCOMM;
					star = 1'b0;
					advance_pos(b);
				end else begin
					emit_byte(held);
					emit_close(single_kind(held), ErrNone);
					mode = MODE_IDLE;
					open_token(b);
				end
			end
			MODE_WORD: begin
				if (word_char(b)) begin
					word_push(b);
					emit_byte(b);
					advance_pos(b);
				end else begin
					emit_close(word_token_kind(), ErrNone);
					cand = '1;
					wlen = '0;
					mode = MODE_IDLE;
					open_token(b);
				end
			end
			MODE_NUM: begin
				if (digit_char(b) || b == ChDot) begin
					emit_byte(b);
					advance_pos(b);
				end else begin
					emit_close(KindNumber, ErrNone);
					mode = MODE_IDLE;
					open_token(b);
				end
			end
			MODE_STR: begin
				advance_pos(b);
				if (b == ChQuote) begin
					emit_close(KindString, ErrNone);
					mode = MODE_IDLE;
				end else if (b == ChBackslash) begin
					mode = MODE_ESC;
				end else begin
					emit_byte(b);
				end
			end
			MODE_ESC: begin
				advance_pos(b);
				case (b)
					"n": emit_byte(ChNewline);
					"t": emit_byte("\t");
					"r": emit_byte(8'h0D);
					ChQuote: emit_byte(ChQuote);
					ChBackslash: emit_byte(ChBackslash);
					default: begin
						emit_byte(ChBackslash);
						emit_byte(b);
					end
				endcase
				mode = MODE_STR;
			end
			MODE_LCOMM: begin
				advance_pos(b);
				if (b == ChNewline)
					mode = MODE_IDLE;
			end
			MODE_BCOMM: begin
				advance_pos(b);
				if (star && b == ChSlash) begin
					mode = MODE_IDLE;
					star = 1'b0;
				end else begin
					star = (b == ChStar);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void close_source();
		logic eof;
		eof = 1'b1;
		case (mode)
			MODE_HELD: begin
				emit_byte(held);
				emit_close(single_kind(held), ErrNone);
			end
			MODE_WORD: emit_close(word_token_kind(), ErrNone);
			MODE_NUM: emit_close(KindNumber, ErrNone);
			MODE_ESC: begin
				emit_byte(ChBackslash);
				emit_close(KindUnknown, ErrUnterminated);
				eof = 1'b0;
			end
			MODE_STR: begin
				emit_close(KindUnknown, ErrUnterminated);
				eof = 1'b0;
			end
			MODE_DEAD: eof = 1'b0;
			default: ;
		endcase
		if (eof)
			emit_rec(1'b1, '0, KindEof, ln, col, ErrNone);
	endfunction

	function automatic void predict_tokens(logic [7:0] b, logic has, logic eos);
		step_recs.delete();
		if (has)
			scan_byte(b);
		if (eos) begin
			close_source();
			lexer_reset();
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, step_recs};
	endfunction

	function automatic void put_byte(logic [7:0] b);
		src_item_t it;
		it.b = b;
		it.has = 1'b1;
		it.eos = 1'b0;
		source_buf = {source_buf, it};
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void put_empty(logic eos);
		src_item_t it;
		it.b = 8'($urandom_range(255));
		it.has = 1'b0;
		it.eos = eos;
		source_buf = {source_buf, it};
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// Closes the source in the buffer and hands it to the driver.
	function automatic void commit_source();
		if (source_buf.size() > 0 && source_buf[source_buf.size() - 1].has
				&& $urandom_range(1))
			source_buf[source_buf.size() - 1].eos = 1'b1;
		else
			put_empty(1'b1);
		foreach (source_buf[i])
			if (source_buf[i].has || source_buf[i].eos)
				items_made++;
		pending_bytes = {pending_bytes, source_buf};
		source_buf.delete();
	endfunction

	function automatic void random_token();
		string wc;
		wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
		case ($urandom_range(13))
			0, 1: begin
				put_text(kw_words[$urandom_range(24)]);
				if ($urandom_range(4) == 0)
					put_byte(pick(wc));
			end
			2: begin
				put_byte(pick("abcxyzQ_"));
				repeat ($urandom_range(11))
					put_byte(pick(wc));
			end
			3: repeat ($urandom_range(1, 5))
				put_byte(pick("0123456789."));
			4: begin
				put_byte(ChQuote);
				repeat ($urandom_range(6)) begin
					if ($urandom_range(3) == 0) begin
						put_byte(ChBackslash);
						put_byte(pick("ntr\"\\qx "));
					end else begin
						put_byte(8'($urandom_range(32, 126)));
					end
				end
				if ($urandom_range(4) != 0)
					put_byte(ChQuote);
			end
			5: begin
				put_byte(pick("+-*/=!<>&|%(){}[],.;:?"));
				if ($urandom_range(1))
					put_byte(pick("=>&|-+"));
			end
			6: put_byte(pick(" \t\r\n"));
			7: begin
				put_text("//");
				repeat ($urandom_range(4))
					put_byte(pick("ab */\""));
				put_byte(ChNewline);
			end
			8: begin
				put_text("/*");
				repeat ($urandom_range(5))
					put_byte(pick("a*/ \n"));
				if ($urandom_range(4) != 0)
					put_text("*/");
			end
			9: put_byte(8'($urandom_range(255)));
			10: put_empty(1'b0);
			default: put_byte(" ");
		endcase
	endfunction

	function automatic void random_source();
		repeat ($urandom_range(1, 8)) begin
			random_token();
			if ($urandom_range(1))
				put_byte(pick("  \n"));
		end
		commit_source();
	endfunction

	task automatic drain();
		while (pending_bytes.size() != 0 || s_tvalid || expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		src_item_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_tokens(s_tdata, s_tuser, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle) begin
					it = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.b;
					s_tuser <= it.has;
					s_tlast <= it.eos;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall);
		end
	end

	always @(posedge clk) begin
		token_rec_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected record beat: tdata=%h tuser=%b", m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_tokens.pop_front();
				if (m_tuser !== e.rtype) begin
					$error("record_type: expected %0d, got %0d", e.rtype, m_tuser);
					errors++;
				end
				if (m_tdata[7:0] !== e.lex) begin
					$error("lexeme_byte: expected %0d, got %0d", e.lex, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[13:8] !== e.kind) begin
					$error("token_kind: expected %0d, got %0d", e.kind, m_tdata[13:8]);
					errors++;
				end
				if (m_tdata[29:14] !== e.line) begin
					$error("start_line: expected %0d, got %0d", e.line, m_tdata[29:14]);
					errors++;
				end
				if (m_tdata[45:30] !== e.col) begin
					$error("start_column: expected %0d, got %0d", e.col, m_tdata[45:30]);
					errors++;
				end
				if (m_tdata[47:46] !== e.err) begin
					$error("error_code: expected %0d, got %0d", e.err, m_tdata[47:46]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_run: expected %0d, got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		lexer_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed sources covering the special cases.
		put_byte(8'h00);
		commit_source();
		put_byte(8'hFF);
		put_text("ab");
		commit_source();
		put_text("a->b!=c||/");
		commit_source();
		put_text("\"a\\n\\q");
		commit_source();
		put_text("/*/x*/1.5");
		commit_source();
		put_text("\"x\\");
		commit_source();
		put_empty(1'b1);
		pending_bytes = {pending_bytes, source_buf};
		source_buf.delete();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle = (ph == 1) ? 66 : (ph == 3) ? 17 : 0;
			rx_stall = (ph == 2) ? 66 : (ph == 3) ? 17 : 0;
			for (int half = 0; half < 2; half++) begin
				while (items_made < 56 * (2 * ph + half + 1) + 25)
					random_source();
				if (ph == 0 && half == 0)
					hold_req = hold_req + 1;
				drain();
			end
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
